/* rtl/kst_pkg.sv */
// Package with shared field widths, operation codes and status codes of the key set table.
`timescale 1ns / 1ps
`default_nettype none
package kst_pkg;

	localparam int OP_W     = 2;
	localparam int KEY_W    = 64;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef logic [OP_W-1:0]     op_t;
	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [COUNT_W-1:0]  count_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_ERASE  = 2'd1;
	localparam op_t OP_QUERY  = 2'd2;

	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_ZERO = 2'd1;
	localparam status_t ST_FULL = 2'd2;

endpackage
`default_nettype wire

/* rtl/kst_req_if.sv */
// Request channel: valid/ready handshake carrying an operation and a key.
`timescale 1ns / 1ps
`default_nettype none
interface kst_req_if
	import kst_pkg::*;
();
	logic valid;
	logic ready;
	op_t  op;
	key_t key;

	modport source (output valid, output op, output key, input ready);
	modport sink (input valid, input op, input key, output ready);
endinterface
`default_nettype wire

/* rtl/kst_rsp_if.sv */
// Response channel: valid/ready handshake carrying the result of one request.
`timescale 1ns / 1ps
`default_nettype none
interface kst_rsp_if
	import kst_pkg::*;
();
	logic    valid;
	logic    ready;
	logic    success;
	logic    found;
	status_t status;
	count_t  count;

	modport source (output valid, output success, output found, output status, output count,
		input ready);
	modport sink (input valid, input success, input found, input status, input count,
		output ready);
endinterface
`default_nettype wire

/* rtl/key_set_table_core.sv */
// Key set table: a fixed-capacity set of nonzero keys held in one synchronous memory.
// Requests are handled one at a time: req.ready is high only in the idle state. A scanned request
//   reads every slot in turn, one read per cycle, then decides; a zero key or an unused op code
//   goes straight to the decide state, which waits while a pending response has not been taken;
//   a new request is taken while the previous response still waits in the output register.
// Reset: arst_n clears control state, then a clearing pass writes zero to every slot with
//   req.ready low; count starts at zero.
`timescale 1ns / 1ps
`default_nettype none
module key_set_table_core
	import kst_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	kst_req_if.sink     req,
	kst_rsp_if.source   rsp
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int ISS_W = IDX_W + 1;

	localparam logic [2:0] S_CLEAR  = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;

	localparam logic [ISS_W-1:0] ISS_END  = ISS_W'(CAPACITY);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

	logic [2:0]       state_q;
	logic [ISS_W-1:0] issue_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	key_t             rd_data_s1;
	logic             hit_q;
	logic             emp_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [IDX_W-1:0] emp_idx_q;
	op_t              op_q;
	key_t             key_q;
	count_t           count_q;

	logic             out_valid_q;
	logic             out_success_q;
	logic             out_found_q;
	status_t          out_status_q;

	key_t             mem_q [CAPACITY];

	logic             req_fire;
	logic             dec_fire;
	logic             mem_re;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	key_t             mem_wdata;
	logic             rd_hit;
	logic             rd_emp;

	logic             res_success;
	logic             res_found;
	status_t          res_status;
	count_t           res_count;

	// Handshake qualifiers
	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign dec_fire  = (state_q == S_DECIDE) && (!out_valid_q || rsp.ready);
	assign mem_re    = (state_q == S_SCAN) && (issue_q < ISS_END);

	// Compare returning slot against the key and against empty
	assign rd_hit = rd_vld_s1 && (rd_data_s1 == key_q);
	assign rd_emp = rd_vld_s1 && (rd_data_s1 == '0);

	// Decide the result and any write-back once the scan is over; drive the clearing writes after reset
	always_comb begin
		res_success = 1'b0;
		res_found   = 1'b0;
		res_status  = ST_OK;
		res_count   = count_q;
		mem_we      = 1'b0;
		mem_waddr   = issue_q[IDX_W-1:0];
		mem_wdata   = '0;
		if (state_q == S_CLEAR) begin
			mem_we = 1'b1;
		end else if (op_q inside {OP_INSERT, OP_ERASE, OP_QUERY}) begin
			if (key_q == '0) begin
				res_status = ST_ZERO;
			end else begin
				res_found = hit_q;
				case (op_q)
					OP_INSERT: begin
						if (hit_q) begin
							res_success = 1'b1;
						end else if (emp_q) begin
							res_success = 1'b1;
							res_count   = count_q + count_t'(1);
							mem_we      = dec_fire;
							mem_waddr   = emp_idx_q;
							mem_wdata   = key_q;
						end else begin
							res_status = ST_FULL;
						end
					end
					OP_ERASE: begin
						res_success = 1'b1;
						if (hit_q) begin
							res_count = count_q - count_t'(1);
							mem_we    = dec_fire;
							mem_waddr = hit_idx_q;
						end
					end
					default: begin
						res_success = hit_q;
					end
				endcase
			end
		end
	end

	// Slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= mem_q[issue_q[IDX_W-1:0]];
		end
	end

	// Sequencer: clear, accept, scan, decide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			emp_q       <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
			// Load a new response or drop the one just taken
			if (dec_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					issue_q <= issue_q + ISS_W'(1);
					if (issue_q[IDX_W-1:0] == IDX_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						issue_q <= '0;
						hit_q   <= 1'b0;
						emp_q   <= 1'b0;
						if (!(req.op inside {OP_INSERT, OP_ERASE, OP_QUERY})) begin
							state_q <= S_DECIDE;
						end else if (req.key == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (mem_re) begin
						issue_q <= issue_q + ISS_W'(1);
					end
					if (rd_hit) begin
						hit_q <= 1'b1;
					end
					if (rd_emp) begin
						emp_q <= 1'b1;
					end
					if (rd_vld_s1 && rd_idx_s1 == IDX_LAST) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (dec_fire) begin
						count_q <= res_count;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request, scan positions and response
	always_ff @(posedge clk) begin
		if (req_fire) begin
			op_q  <= req.op;
			key_q <= req.key;
		end
		if (mem_re) begin
			rd_idx_s1 <= issue_q[IDX_W-1:0];
		end
		if (rd_hit && !hit_q) begin
			hit_idx_q <= rd_idx_s1;
		end
		if (rd_emp && !emp_q) begin
			emp_idx_q <= rd_idx_s1;
		end
		if (dec_fire) begin
			out_success_q <= res_success;
			out_found_q   <= res_found;
			out_status_q  <= res_status;
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.success = out_success_q;
	assign rsp.found   = out_found_q;
	assign rsp.status  = out_status_q;
	assign rsp.count   = count_q;

	// The count never exceeds the number of slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CAPACITY > 127) || (count_q <= count_t'(CAPACITY)))
		else $error("occupied count exceeds capacity");

	// Slot data only returns while a scan is in progress
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_SCAN))
		else $error("read data outside scan");

	// A full-table response never reports success or a hit
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == ST_FULL) |-> (!out_success_q && !out_found_q))
		else $error("full status with success or hit");

	// A pending response is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |-> !dec_fire)
		else $error("response overwritten");

endmodule
`default_nettype wire

/* tb/kst_table_checker.sv */
// Checker for the key set table: tracks the slot contents, predicts each response, compares.
`timescale 1ns / 1ps
`default_nettype none
module kst_table_checker
	import kst_pkg::*;
#(
	parameter int CAPACITY = 64
) (
	input  wire         clk,
	input  wire         arst_n,
	kst_req_if          req,
	kst_rsp_if          rsp,
	output int unsigned fault_count,
	output int unsigned awaited,
	output int unsigned answered,
	output int unsigned hits,
	output int unsigned full_refusals,
	output int unsigned zero_rejects
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic    success;
		logic    found;
		status_t status;
		count_t  count;
	} outcome_t;

	// Shadow copy of the store; the count wraps at its 7-bit width like the block's
	key_t     table_slots [CAPACITY];
	count_t   live_count;
	outcome_t outcome_q [$];
	int       reported;

	// Apply one request to the shadow store and return the response it must give
	function automatic outcome_t apply_request(input op_t op, input key_t key);
		outcome_t res;
		int       hit_at;
		int       free_at;
		res = '0;
		res.status = ST_OK;
		if (op == OP_INSERT || op == OP_ERASE || op == OP_QUERY) begin
			if (key == '0) begin
				res.status = ST_ZERO;
			end else begin
				hit_at  = -1;
				free_at = -1;
				for (int i = 0; i < CAPACITY; i++) begin
					if (hit_at < 0 && table_slots[i] == key)
						hit_at = i;
					if (free_at < 0 && table_slots[i] == '0)
						free_at = i;
				end
				res.found = (hit_at >= 0);
				case (op)
					OP_INSERT: begin
						if (res.found) begin
							res.success = 1'b1;
						end else if (free_at >= 0) begin
							table_slots[free_at] = key;
							live_count = live_count + 1'b1;
							res.success = 1'b1;
						end else begin
							res.status = ST_FULL;
						end
					end
					OP_ERASE: begin
						if (res.found) begin
							table_slots[hit_at] = '0;
							live_count = live_count - 1'b1;
						end
						res.success = 1'b1;
					end
					default: begin
						res.success = res.found;
					end
				endcase
			end
		end
		res.count = live_count;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		outcome_t got;
		outcome_t pred;
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++)
				table_slots[i] = '0;
			live_count = '0;
			outcome_q.delete();
			reported = 0;
			fault_count   <= 0;
			awaited       <= 0;
			answered      <= 0;
			hits          <= 0;
			full_refusals <= 0;
			zero_rejects  <= 0;
		end else begin
			// Compare the response transaction against the oldest prediction
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.success, rsp.found, rsp.status, rsp.count};
				answered <= answered + 1;
				if (outcome_q.size() == 0) begin
					fault_count <= fault_count + 1;
					if (reported < REPORT_LIMIT)
						$display("%0t: response with nothing outstanding: %s",
							$realtime, $sformatf("success=%0d found=%0d status=%0d count=%0d",
							got.success, got.found, got.status, got.count));
					reported++;
				end else begin
					want = outcome_q.pop_front();
					if (got.success !== want.success || got.found !== want.found ||
							got.status !== want.status || got.count !== want.count) begin
						fault_count <= fault_count + 1;
						if (reported < REPORT_LIMIT) begin
							$display("%0t: response mismatch: exp %s,", $realtime,
								$sformatf("success=%0d found=%0d status=%0d count=%0d",
								want.success, want.found, want.status, want.count));
							$display("    got success=%0d found=%0d status=%0d count=%0d",
								got.success, got.found, got.status, got.count);
						end
						reported++;
					end
					if (want.found)
						hits <= hits + 1;
					if (want.status == ST_FULL)
						full_refusals <= full_refusals + 1;
					if (want.status == ST_ZERO)
						zero_rejects <= zero_rejects + 1;
				end
			end
			// Predict the response to each accepted request transaction
			if (req.valid && req.ready) begin
				pred = apply_request(req.op, req.key);
				outcome_q.insert(outcome_q.size(), pred);
			end
			awaited <= outcome_q.size();
		end
	end

endmodule
`default_nettype wire

/* tb/tb_key_set_table_core.sv */
// Testbench top for the key set table: drives requests and response back-pressure, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_key_set_table_core;
	import kst_pkg::*;

	localparam int  CAPACITY     = 64;
	localparam op_t OP_UNUSED    = 2'd3;
	localparam int  RANDOM_ITEMS = 1430;
	localparam int  POOL_SIZE    = 80;
	localparam int  STALL_LIMIT  = 5000;
	localparam int  HOLD_AT      = 15000;
	localparam int  HOLD_OFF     = 600;

	typedef enum {FILL_UP, DRAIN_OUT, MIXED} mix_t;

	logic clk;
	logic arst_n;

	kst_req_if req ();
	kst_rsp_if rsp ();

	int unsigned fault_count;
	int unsigned awaited;
	int unsigned answered;
	int unsigned hits;
	int unsigned full_refusals;
	int unsigned zero_rejects;

	key_t        key_pool [POOL_SIZE];
	bit          sender_calm;
	int unsigned idle_cycles;
	int unsigned rx_cycle;
	int          stall_left;
	int          calm_left;

	key_set_table_core #(.CAPACITY(CAPACITY)) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	kst_table_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.fault_count   (fault_count),
		.awaited       (awaited),
		.answered      (answered),
		.hits          (hits),
		.full_refusals (full_refusals),
		.zero_rejects  (zero_rejects)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic key_t random_key();
		return {$urandom, $urandom};
	endfunction

	function automatic op_t valid_op(input int unsigned pick);
		case (pick % 3)
			0:       return OP_INSERT;
			1:       return OP_ERASE;
			default: return OP_QUERY;
		endcase
	endfunction

	// Mostly back-to-back, sometimes a few cycles, rarely a long gap; no gap while the sender is calm
	function automatic int sender_gap();
		int unsigned r;
		if (sender_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Offer one request transaction and hold it until accepted
	task automatic send_request(input op_t op, input key_t key);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.op    <= op;
		req.key   <= key;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
				STALL_LIMIT, awaited);
			$display("tb_key_set_table_core failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Response back-pressure: random stalls, calm stretches and one long hold-off
	initial begin
		rsp.ready <= 1'b0;
		rx_cycle   = 0;
		stall_left = 0;
		calm_left  = 0;
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle == HOLD_AT) begin
				rsp.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else if (calm_left > 0) begin
				rsp.ready <= 1'b1;
				calm_left--;
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:69]:  rsp.ready <= 1'b1;
					[70:89]: begin
						rsp.ready <= 1'b0;
						stall_left = $urandom_range(0, 3);
					end
					[90:95]: begin
						rsp.ready <= 1'b0;
						stall_left = $urandom_range(4, 19);
					end
					[96:97]: begin
						rsp.ready <= 1'b0;
						stall_left = $urandom_range(30, 60);
					end
					default: begin
						rsp.ready <= 1'b1;
						calm_left = $urandom_range(100, 400);
					end
				endcase
			end
		end
	end

	// Stimulus: directed corner cases, then phased random traffic over a key pool
	initial begin
		mix_t        mode;
		int          phase_len;
		int          sent;
		int unsigned cursor;
		int unsigned idx;
		int unsigned r;
		int unsigned s;
		op_t         op;
		key_t        key;
		bit          from_pool;

		arst_n    <= 1'b0;
		req.valid <= 1'b0;
		req.op    <= OP_QUERY;
		req.key   <= '0;
		sender_calm = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, duplicates, extreme keys, zero key, unused op code
		send_request(OP_QUERY,  64'd1);
		send_request(OP_ERASE,  64'd1);
		send_request(OP_INSERT, '1);
		send_request(OP_INSERT, 64'd1);
		send_request(OP_INSERT, '1);
		send_request(OP_QUERY,  '1);
		send_request(OP_QUERY,  64'd1);
		send_request(OP_INSERT, 64'h8000_0000_0000_0000);
		send_request(OP_ERASE,  64'd1);
		send_request(OP_QUERY,  64'd1);
		send_request(OP_INSERT, 64'h5555_5555_5555_5555);
		send_request(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(OP_INSERT, '0);
		send_request(OP_ERASE,  '0);
		send_request(OP_QUERY,  '0);
		send_request(OP_UNUSED, '0);
		send_request(OP_UNUSED, '1);
		send_request(OP_ERASE,  '1);
		send_request(OP_INSERT, 64'd2);

		// Seed the pool with the keys still held so that they drain later
		key_pool[0] = 64'h8000_0000_0000_0000;
		key_pool[1] = 64'h5555_5555_5555_5555;
		key_pool[2] = 64'hAAAA_AAAA_AAAA_AAAA;
		key_pool[3] = 64'd2;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = (i % 3 == 0) ? key_t'($urandom_range(1, 255)) : random_key();

		// Random: phases that fill, drain or mix, so the full-table case is reached
		sent   = 0;
		cursor = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 2))
				0:       mode = FILL_UP;
				1:       mode = DRAIN_OUT;
				default: mode = MIXED;
			endcase
			phase_len   = $urandom_range(30, 120);
			sender_calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
				from_pool = 1'b0;
				idx       = 0;
				r = $urandom_range(0, 99);
				if (r < 3) begin
					op  = OP_UNUSED;
					key = $urandom_range(0, 1) ? random_key() : key_t'(0);
				end else if (r < 7) begin
					op  = valid_op($urandom);
					key = '0;
				end else if (r < 12) begin
					op  = $urandom_range(0, 1) ? OP_QUERY : OP_ERASE;
					key = random_key();
				end else begin
					from_pool = 1'b1;
					if ($urandom_range(0, 9) < 6) begin
						idx    = cursor;
						cursor = (cursor + 1) % POOL_SIZE;
					end else begin
						idx = $urandom_range(0, POOL_SIZE - 1);
					end
					key = key_pool[idx];
					s = $urandom_range(0, 99);
					case (mode)
						FILL_UP:   op = (s < 75) ? OP_INSERT : (s < 90) ? OP_QUERY : OP_ERASE;
						DRAIN_OUT: op = (s < 70) ? OP_ERASE : (s < 85) ? OP_QUERY : OP_INSERT;
						default:   op = valid_op(s);
					endcase
				end
				send_request(op, key);
				sent++;
				// Refresh a drained pool key: it is absent now, so a new value stays safe
				if (from_pool && op == OP_ERASE && mode == DRAIN_OUT && $urandom_range(0, 3) == 0)
					key_pool[idx] = random_key();
			end
		end
		req.valid <= 1'b0;

		// Drain outstanding responses, then allow a full scan for anything stray
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);

		$display("Run covered %0d responses: %0d on a key already held, %0d refused on a full table, %0d zero-key rejections.",
			answered, hits, full_refusals, zero_rejects);
		$display("Mismatches: %0d, responses still outstanding: %0d.", fault_count, awaited);
		if (fault_count == 0 && awaited == 0) begin
			$display("tb_key_set_table_core passed");
		end else begin
			$display("tb_key_set_table_core failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
